// ----- rtl/core/gccg_pkg.sv -----
// Shared types and constants of the Gray-code combination generator.
`default_nettype none

package gccg_pkg;

  // Largest set the block enumerates; the membership and pointer arrays have one slot more.
  localparam int MAX_SET   = 16;
  localparam int NUM_SLOTS = MAX_SET + 1;
  localparam int ADDR_W    = $clog2(MAX_SET);

  // Command codes on the input channel.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_NEXT  = 2'd2;

  // Status codes on the result channel.
  localparam logic [2:0] ST_ELEMENT   = 3'd0;
  localparam logic [2:0] ST_STARTED   = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_BAD_SIZES = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_SET_SIZE    = 1'b0;
  localparam logic CFG_SUBSET_SIZE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_START,
    OP_NEXT
  } op_t;

  // One classified command waiting for the back end.
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] index;
    logic [31:0]       value;
  } q_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/gccg_front.sv -----
// Front end: accepts input words, classifies commands and queues them for the back end.
`default_nettype none

module gccg_front import gccg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [ADDR_W-1:0]  load_index,
  input  logic signed [31:0] element_value,
  output logic               q_valid,
  output q_word_t            q_word,
  input  logic               q_pop
);

  localparam int QUEUE_DEPTH = 2;

  q_word_t    entries [0:QUEUE_DEPTH-1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  op_t  op;
  logic keep;
  logic push;
  logic pop;

  // Drop the unused command code here; it is accepted but never queued.
  always_comb begin
    unique case (cmd)
      CMD_LOAD: begin
        op   = OP_LOAD;
        keep = 1'b1;
      end
      CMD_START: begin
        op   = OP_START;
        keep = 1'b1;
      end
      CMD_NEXT: begin
        op   = OP_NEXT;
        keep = 1'b1;
      end
      default: begin
        op   = OP_LOAD;
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = (count == 2'(QUEUE_DEPTH));
  assign q_valid  = (count != 2'd0);
  assign q_word   = entries[rd_ptr];
  assign push     = in_valid && !in_stall && keep;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{op: op, index: load_index, value: element_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gccg_back.sv -----
// Back end: element store, duplicate check, subset scan and Gray-code advance.
`default_nettype none

module gccg_back import gccg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  q_word_t            q_word,
  output logic               q_pop,
  input  logic [4:0]         set_size,
  input  logic [4:0]         subset_size,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [31:0] subset_element,
  output logic [15:0]        subset_number,
  output logic               last_of_subset,
  output logic [2:0]         status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUP_RD,
    S_DUP_CMP,
    S_INIT,
    S_SCAN,
    S_SEND,
    S_ADV,
    S_RESP
  } state_t;

  function automatic logic in_rng(logic signed [6:0] x);
    return !x[6] && (x[5:0] <= 6'(MAX_SET));
  endfunction

  function automatic logic [NUM_SLOTS-1:0] onehot(logic signed [6:0] x);
    logic [NUM_SLOTS-1:0] m;
    m = '0;
    if (in_rng(x)) m[x[4:0]] = 1'b1;
    return m;
  endfunction

  function automatic logic bget(logic [NUM_SLOTS-1:0] v, logic signed [6:0] x);
    return in_rng(x) ? v[x[4:0]] : 1'b0;
  endfunction

  function automatic logic [NUM_SLOTS-1:0] lowmask(logic [4:0] c);
    logic [NUM_SLOTS-1:0] m;
    for (int j = 0; j < NUM_SLOTS; j++) m[j] = (5'(j) < c);
    return m;
  endfunction

  state_t state;

  logic [31:0]       store [0:MAX_SET-1];
  logic [31:0]       rd_a;
  logic [31:0]       rd_b;
  logic              mem_we;
  logic              rda_en;
  logic              rdb_en;
  logic [ADDR_W-1:0] rda_addr;
  logic [ADDR_W-1:0] rdb_addr;

  logic [NUM_SLOTS-1:0] bits;
  logic [4:0]           fp [0:NUM_SLOTS-1];
  logic [4:0]           t;
  logic [15:0]          counter;
  logic                 running;
  logic [4:0]           lat_n;
  logic [4:0]           lat_k;
  logic [4:0]           a;
  logic [4:0]           b;
  logic [4:0]           p;
  logic                 last_r;
  logic [2:0]           resp_st;
  logic                 resp_after;

  logic       out_free;
  logic       out_load;
  logic       bad_sizes;
  logic [4:0] scan_j;
  logic       scan_hit;

  // Advance datapath.
  logic [4:0]           adv_i;
  logic [4:0]           adv_pi;
  logic signed [6:0]    si;
  logic signed [6:0]    st;
  logic signed [6:0]    im1;
  logic signed [6:0]    flip_x;
  logic signed [6:0]    t1;
  logic signed [6:0]    t2;
  logic                 bi;
  logic                 tcond;
  logic [NUM_SLOTS-1:0] b2;
  logic [4:0]           fp0_a;
  logic [4:0]           fp0_fin;

  assign out_free  = !out_valid || !out_stall;
  assign out_load  = ((state == S_SEND) || (state == S_RESP)) && out_free;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign bad_sizes = (set_size == 5'd0) || (set_size > 5'(MAX_SET)) ||
                     (subset_size == 5'd0) || (subset_size > set_size);
  assign scan_j    = lat_n - 5'd1 - p;
  assign scan_hit  = bits[scan_j];

  assign mem_we   = q_pop && (q_word.op == OP_LOAD);
  assign rda_en   = (state == S_DUP_RD) || ((state == S_SCAN) && scan_hit);
  assign rda_addr = (state == S_DUP_RD) ? a[ADDR_W-1:0] : p[ADDR_W-1:0];
  assign rdb_en   = (state == S_DUP_RD);
  assign rdb_addr = b[ADDR_W-1:0];

  always_comb begin
    adv_i   = fp[0];
    adv_pi  = (adv_i <= 5'(MAX_SET)) ? fp[adv_i] : 5'd0;
    si      = {2'b00, adv_i};
    st      = {2'b00, t};
    im1     = si - 7'sd1;
    bi      = bget(bits, si);
    if (bi) begin
      flip_x = (st != 7'sd0) ? st - 7'sd1 : im1;
      t1     = st + 7'sd1;
    end else begin
      flip_x = (st != 7'sd1) ? st - 7'sd2 : im1;
      t1     = st - 7'sd1;
    end
    b2      = bits ^ onehot(flip_x) ^ onehot(si);
    fp0_a   = (adv_i == 5'd0) ? 5'd1 : adv_pi;
    tcond   = (t1 == si) || (t1 == 7'sd0);
    t2      = tcond ? t1 + 7'sd1 : t1 - 7'(bget(b2, im1));
    fp0_fin = tcond ? fp0_a : ((t2 == 7'sd0) ? im1[4:0] : t2[4:0]);
  end

  always_ff @(posedge clk) begin
    if (mem_we) store[q_word.index] <= q_word.value;
    if (rda_en) rd_a <= store[rda_addr];
    if (rdb_en) rd_b <= store[rdb_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      running   <= 1'b0;
      out_valid <= 1'b0;
      bits      <= '0;
      t         <= 5'd0;
      counter   <= 16'd0;
      for (int j = 0; j < NUM_SLOTS; j++) fp[j] <= 5'd0;
    end else begin
      if (!out_stall && !out_load) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_word.op)
              OP_LOAD: begin
              end
              OP_START: begin
                running <= 1'b0;
                lat_n   <= set_size;
                lat_k   <= subset_size;
                a       <= 5'd0;
                b       <= 5'd1;
                if (bad_sizes) begin
                  resp_st <= ST_BAD_SIZES;
                  state   <= S_RESP;
                end else if (set_size == 5'd1) begin
                  state <= S_INIT;
                end else begin
                  state <= S_DUP_RD;
                end
              end
              OP_NEXT: begin
                if (!running) begin
                  resp_st <= ST_EXHAUSTED;
                  state   <= S_RESP;
                end else begin
                  counter <= counter + 16'd1;
                  p       <= 5'd0;
                  if ((bits & lowmask(lat_n)) == '0) begin
                    resp_st    <= ST_EXHAUSTED;
                    resp_after <= 1'b1;
                    state      <= S_ADV;
                  end else begin
                    resp_after <= 1'b0;
                    state      <= S_SCAN;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DUP_RD: begin
          state <= S_DUP_CMP;
        end
        S_DUP_CMP: begin
          if (rd_a == rd_b) begin
            resp_st <= ST_DUPLICATE;
            state   <= S_RESP;
          end else if (b == lat_n - 5'd1) begin
            if (a == lat_n - 5'd2) begin
              state <= S_INIT;
            end else begin
              a     <= a + 5'd1;
              b     <= a + 5'd2;
              state <= S_DUP_RD;
            end
          end else begin
            b     <= b + 5'd1;
            state <= S_DUP_RD;
          end
        end
        S_INIT: begin
          bits <= lowmask(lat_k);
          for (int j = 1; j < NUM_SLOTS; j++) fp[j] <= 5'(j + 1);
          fp[0]   <= lat_k;
          t       <= lat_k;
          counter <= 16'd0;
          running <= 1'b1;
          resp_st <= ST_STARTED;
          state   <= S_RESP;
        end
        S_SCAN: begin
          // Step down the membership bits; a set bit fetches its element.
          if (scan_hit) begin
            last_r <= ((bits & lowmask(scan_j)) == '0);
            state  <= S_SEND;
          end else begin
            p <= p + 5'd1;
          end
        end
        S_SEND: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            subset_element <= rd_a;
            subset_number  <= counter;
            last_of_subset <= last_r;
            status         <= ST_ELEMENT;
            p              <= p + 5'd1;
            state          <= last_r ? S_ADV : S_SCAN;
          end
        end
        S_ADV: begin
          // Pointer 0 takes its final value; pointers i and i-1 are updated only when nonzero.
          fp[0] <= fp0_fin;
          if (adv_i != 5'd0 && adv_i <= 5'(MAX_SET)) fp[adv_i] <= adv_i + 5'd1;
          if (!tcond && in_rng(im1) && (im1 != 7'sd0)) fp[im1[4:0]] <= fp0_a;
          bits  <= b2;
          t     <= t2[4:0];
          if (adv_i == lat_n) running <= 1'b0;
          state <= resp_after ? S_RESP : S_IDLE;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            subset_element <= '0;
            subset_number  <= 16'd0;
            last_of_subset <= 1'b1;
            status         <= resp_st;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_elem_numbered: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ELEMENT) |-> subset_number != 16'd0)
    else $error("element word without a subset number");

  a_status_word_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_ELEMENT) |-> last_of_subset && (subset_element == 32'sd0))
    else $error("status word not closed or carries an element");

  a_running_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(running) |-> ($past(state) == S_ADV) || ($past(state) == S_IDLE))
    else $error("enumeration stopped outside advance or start");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/gray_code_combination_generator_top.sv -----
// Top level of the Gray-code combination generator: configuration registers and front/back ends.
// Usage:
//   Input channel (in_valid / in_stall, cmd, load_index, element_value) takes one command
//   word per handshake. A load writes one entry of the element store and returns nothing;
//   a start checks the sizes and the loaded elements for duplicates and returns one status
//   word; a next returns the current subset, one word per element in ascending set
//   position with last_of_subset on the final word, or one exhausted status word.
//   The unused command code is accepted and dropped.
//   Output channel (out_valid / out_stall) carries result words from an output register.
//   Commands pass through a two-word queue, so the input accepts up to two words while results wait.
// Command flow:
//   A load is written to the store as it is popped from the queue. A start runs the pairwise
//   compare through the store's two read ports, one pair at a time. A next, while running,
//   scans the set positions, sends one word per element found and ends with the pointer advance.
// Reset (rst, synchronous): empties the queue and output register, clears the membership
//   bits, focus pointers and running flag, sets both size registers to 1. The element store is
//   undefined until loaded; there is no clearing pass.
// A stalled output holds its word, and the back end waits while the queue fills.
`default_nettype none

module gray_code_combination_generator_top import gccg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [3:0]         load_index,
  input  logic signed [31:0] element_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] subset_element,
  output logic [15:0]        subset_number,
  output logic               last_of_subset,
  output logic [2:0]         status,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data
);

  // Size registers; a start samples them.
  logic [4:0] set_size;
  logic [4:0] subset_size;

  // Queue between front and back.
  logic    q_valid;
  q_word_t q_word;
  logic    q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size    <= 5'd1;
      subset_size <= 5'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SET_SIZE:    set_size    <= cfg_data;
        CFG_SUBSET_SIZE: subset_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Accept and classify command words, hold up to two.
  gccg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .load_index    (load_index),
    .element_value (element_value),
    .q_valid       (q_valid),
    .q_word        (q_word),
    .q_pop         (q_pop)
  );

  // Execute commands and drive the result register.
  gccg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_word         (q_word),
    .q_pop          (q_pop),
    .set_size       (set_size),
    .subset_size    (subset_size),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .subset_element (subset_element),
    .subset_number  (subset_number),
    .last_of_subset (last_of_subset),
    .status         (status)
  );

endmodule

`default_nettype wire
